/* src/mbet_pkg.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, constants and the sequencer state type for the escape-time
// unit and its multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

    // Coordinate format: signed fixed point.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;

    // Full product width and the widened width used for sums and updates.
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 1;

    localparam int COUNT_WIDTH = 16;

    // Escape threshold: |z|^2 > 4, scaled by 2^(2*FRAC_BITS).
    localparam logic [ACC_WIDTH-1:0] ESCAPE_LIMIT =
        ACC_WIDTH'(1) << (2 * FRAC_BITS + 2);

    // Saturation bounds of a coordinate, held at the widened width.
    localparam logic signed [ACC_WIDTH-1:0] COORD_MAX_EXT =
        (ACC_WIDTH'(1) << (COORD_WIDTH - 1)) - ACC_WIDTH'(1);
    localparam logic signed [ACC_WIDTH-1:0] COORD_MIN_EXT =
        -(ACC_WIDTH'(1) << (COORD_WIDTH - 1));

    // Configuration register map.
    localparam int                      PADDR_WIDTH      = 3;
    localparam logic                    REG_ITER_LIMIT   = 1'b0;
    localparam logic [COUNT_WIDTH-1:0]  ITER_LIMIT_RESET = 16'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CROSS,
        ST_TEST,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* src/mbet_mul.sv */
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One signed coordinate-by-coordinate multiply with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_mul (
    input  wire logic                                    aclk,
    input  wire logic signed [mbet_pkg::COORD_WIDTH-1:0] op_a,
    input  wire logic signed [mbet_pkg::COORD_WIDTH-1:0] op_b,
    output logic signed [mbet_pkg::PROD_WIDTH-1:0]       product
);

    logic signed [mbet_pkg::PROD_WIDTH-1:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= mbet_pkg::PROD_WIDTH'(op_a) * mbet_pkg::PROD_WIDTH'(op_b);
    end

    assign product = product_reg;

endmodule

`default_nettype wire

/* src/mandelbrot_escape_time_unit.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Iterates z = z*z + c for one point and reports the escape index.
// ----------------------------------------------------------------------------
// The input stream carries one complex point c per transfer, as two signed
// Q3.28 coordinates. The unit starts with z = c and iterates z = z*z + c,
// testing |z|^2 > 4 before each update, and sends one result transfer per
// point: the escape index (or the iteration limit) and an escaped flag.
// The iteration limit is set through the APB port (register 0, reset 256).
//
// One multiplier is shared under a small sequencer. Each iteration runs
// three products (zr*zr, zi*zi, zr*zi) through the registered multiplier,
// an escape test, then the coordinate update with saturation.
// s_tready is high only while no point is being iterated, so a new point
// is accepted only once the previous one has left the sequencer.
//
// Results sit in an output register. The next point is accepted while a
// result still waits there; a finished point whose result cannot be stored
// because the receiver stalls waits in the final state until it is taken.
// Synchronous reset empties the output register, returns the sequencer to
// idle and restores the iteration limit to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [63:0]                          s_tdata,  // [31:0] point_real, [63:32] point_imag
    // Result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [15:0]                               m_tdata,  // [15:0] escape_count
    output logic                                      m_tuser,  // [0] escaped
    // Configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mbet_pkg::PADDR_WIDTH-1:0]     paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    localparam int CW = mbet_pkg::COORD_WIDTH;
    localparam int PW = mbet_pkg::PROD_WIDTH;
    localparam int AW = mbet_pkg::ACC_WIDTH;
    localparam int NW = mbet_pkg::COUNT_WIDTH;

    mbet_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0] cr_reg, cr_next;
    logic signed [CW-1:0] ci_reg, ci_next;
    logic signed [CW-1:0] zr_reg, zr_next;
    logic signed [CW-1:0] zi_reg, zi_next;
    logic [NW-1:0]        idx_reg, idx_next;
    logic                 esc_reg, esc_next;
    logic [PW-1:0]        r2_reg, r2_next;
    logic [PW-1:0]        i2_reg, i2_next;
    logic signed [PW-1:0] diff_reg, diff_next;
    logic signed [PW-1:0] cross_reg, cross_next;

    logic                 out_valid_reg, out_valid_next;
    logic [NW-1:0]        out_count_reg, out_count_next;
    logic                 out_escaped_reg, out_escaped_next;

    logic [NW-1:0]        limit_reg, limit_next;

    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    logic [AW-1:0]        mag_sum;
    logic signed [AW-1:0] zr_sum, zi_sum;
    logic                 in_fire, cfg_write, cfg_hit;

    // Clamp a widened value to the coordinate range.
    function automatic logic signed [CW-1:0] sat_coord(input logic signed [AW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > mbet_pkg::COORD_MAX_EXT) begin
            r = mbet_pkg::COORD_MAX_EXT[CW-1:0];
        end else if (v < mbet_pkg::COORD_MIN_EXT) begin
            r = mbet_pkg::COORD_MIN_EXT[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    mbet_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == mbet_pkg::ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_count_reg;
    assign m_tuser   = out_escaped_reg;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == mbet_pkg::REG_ITER_LIMIT);
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = cfg_hit ? {16'd0, limit_reg} : 32'd0;

    // Squared magnitude; both squares are non-negative, so no sign is lost.
    assign mag_sum = AW'(r2_reg) + AW'(i2_reg);

    // Floor division by 2^FRAC_BITS is an arithmetic shift. The cross term
    // carries the factor two, so it shifts by one place less.
    assign zr_sum = (AW'(diff_reg) >>> mbet_pkg::FRAC_BITS) + AW'(cr_reg);
    assign zi_sum = (AW'(cross_reg) >>> (mbet_pkg::FRAC_BITS - 1)) + AW'(ci_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        case (state_reg)
            mbet_pkg::ST_SQ_RE: begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            mbet_pkg::ST_SQ_IM: begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default: begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mbet_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            limit_reg     <= mbet_pkg::ITER_LIMIT_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        cr_reg          <= cr_next;
        ci_reg          <= ci_next;
        zr_reg          <= zr_next;
        zi_reg          <= zi_next;
        idx_reg         <= idx_next;
        esc_reg         <= esc_next;
        r2_reg          <= r2_next;
        i2_reg          <= i2_next;
        diff_reg        <= diff_next;
        cross_reg       <= cross_next;
        out_count_reg   <= out_count_next;
        out_escaped_reg <= out_escaped_next;
    end

    always_comb begin
        state_next       = state_reg;
        cr_next          = cr_reg;
        ci_next          = ci_reg;
        zr_next          = zr_reg;
        zi_next          = zi_reg;
        idx_next         = idx_reg;
        esc_next         = esc_reg;
        r2_next          = r2_reg;
        i2_next          = i2_reg;
        diff_next        = diff_reg;
        cross_next       = cross_reg;
        out_count_next   = out_count_reg;
        out_escaped_next = out_escaped_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        limit_next       = limit_reg;

        if (cfg_write && cfg_hit) begin
            limit_next = pwdata[NW-1:0];
        end

        case (state_reg)
            mbet_pkg::ST_IDLE: begin
                if (in_fire) begin
                    cr_next  = s_tdata[CW-1:0];
                    ci_next  = s_tdata[2*CW-1:CW];
                    zr_next  = s_tdata[CW-1:0];
                    zi_next  = s_tdata[2*CW-1:CW];
                    idx_next = '0;
                    esc_next = 1'b0;
                    // A zero limit runs no iteration at all.
                    if (limit_reg == '0) begin
                        state_next = mbet_pkg::ST_DONE;
                    end else begin
                        state_next = mbet_pkg::ST_SQ_RE;
                    end
                end
            end
            mbet_pkg::ST_SQ_RE: begin
                state_next = mbet_pkg::ST_SQ_IM;
            end
            mbet_pkg::ST_SQ_IM: begin
                r2_next    = mul_p;
                state_next = mbet_pkg::ST_CROSS;
            end
            mbet_pkg::ST_CROSS: begin
                i2_next    = mul_p;
                state_next = mbet_pkg::ST_TEST;
            end
            mbet_pkg::ST_TEST: begin
                cross_next = mul_p;
                diff_next  = $signed(r2_reg) - $signed(i2_reg);
                if (mag_sum > mbet_pkg::ESCAPE_LIMIT) begin
                    esc_next   = 1'b1;
                    state_next = mbet_pkg::ST_DONE;
                end else begin
                    state_next = mbet_pkg::ST_UPDATE;
                end
            end
            mbet_pkg::ST_UPDATE: begin
                zr_next  = sat_coord(zr_sum);
                zi_next  = sat_coord(zi_sum);
                idx_next = idx_reg + NW'(1);
                if (idx_reg + NW'(1) == limit_reg) begin
                    state_next = mbet_pkg::ST_DONE;
                end else begin
                    state_next = mbet_pkg::ST_SQ_RE;
                end
            end
            mbet_pkg::ST_DONE: begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next   = 1'b1;
                    out_count_next   = idx_reg;
                    out_escaped_next = esc_reg;
                    state_next       = mbet_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mbet_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/mbet_checker.sv */
// ----------------------------------------------------------------------------
// Escape-time unit port checker
// Concurrent checks on the stream ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // Once a point is taken, the unit is busy iterating it.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a point is in flight");

    // No result can appear in the cycle straight after a point is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time_unit mbet_checker u_mbet_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
